>>> rtl/mbg_pkg.sv
// Shared types and constants for the maze backtracker generator.
`timescale 1ns / 1ps

package mbg_pkg;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned RAND_W  = 16;
  localparam int unsigned COORD_W = 7;
  localparam int unsigned DEPTH_W = 11;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned NDIR    = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd16;

  // register indexes on the cfg port
  localparam logic REG_MAZE_WIDTH  = 1'b0;
  localparam logic REG_MAZE_HEIGHT = 1'b1;

  typedef enum logic [EVENT_W-1:0] {
    EV_START = 3'd0,
    EV_CARVE = 3'd1,
    EV_BACK  = 3'd2,
    EV_ENDS  = 3'd3,
    EV_DONE  = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CARVE = 2'd1,
    PH_ENDS  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_EVAL = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef struct packed {
    logic found;
    dir_t dir;
  } pick_t;

endpackage

>>> rtl/mbg_visit_mem.sv
// Visited map: one row of cells per word, two read ports, one write port.
`timescale 1ns / 1ps

module mbg_visit_mem #(
  parameter int ROWS = 32,
  parameter int COLS = 32,
  parameter int AW   = 5
) (
  input  logic            clk,
  input  logic            rd0_en,
  input  logic [AW-1:0]   rd0_addr,
  output logic [COLS-1:0] rd0_data,
  input  logic            rd1_en,
  input  logic [AW-1:0]   rd1_addr,
  output logic [COLS-1:0] rd1_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [COLS-1:0] wr_data
);

  logic [COLS-1:0] mem_r [ROWS];
  logic [COLS-1:0] rd0_data_r;
  logic [COLS-1:0] rd1_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd0_en) begin
      rd0_data_r <= mem_r[rd0_addr];
    end
    if (rd1_en) begin
      rd1_data_r <= mem_r[rd1_addr];
    end
  end

  assign rd0_data = rd0_data_r;
  assign rd1_data = rd1_data_r;

endmodule

>>> rtl/mbg_stack_mem.sv
// Cell stack: one read port, one write port, registered read data.
`timescale 1ns / 1ps

module mbg_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 10,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mbg_pick.sv
// Neighbor choice: counts open directions and selects index (rand*count)>>16.
`timescale 1ns / 1ps

module mbg_pick
  import mbg_pkg::*;
(
  input  logic [NDIR-1:0]   open_mask,
  input  logic [RAND_W-1:0] rand_value,
  output pick_t             pick
);

  logic [2:0]        n;
  logic [RAND_W+2:0] prod;
  logic [2:0]        k;
  logic [2:0]        seen;

  always_comb begin
    n = 3'(open_mask[0]) + 3'(open_mask[1]) + 3'(open_mask[2]) + 3'(open_mask[3]);
    prod = {3'b000, rand_value} * {{RAND_W{1'b0}}, n};
    k = prod[RAND_W+2:RAND_W];
    pick.found = 1'b0;
    pick.dir = DIR_UP;
    seen = 3'd0;
    for (int d = 0; d < NDIR; d++) begin
      if (open_mask[d]) begin
        if (!pick.found && seen == k) begin
          pick.found = 1'b1;
          pick.dir = dir_t'(d[1:0]);
        end
        seen = seen + 3'd1;
      end
    end
  end

endmodule

>>> rtl/maze_backtracker_generator_unit.sv
// Top level: randomized depth-first maze carver around visited-map and stack memories.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_rand_value, in_restart
//   out     | output    | out_valid / out_ready| event, wall x/y, cell x/y, depth
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item starts from ST_IDLE, reading visited-map rows y-1 and y+1, then row y in
// ST_RD (over two read ports), and does its choice and write-back in ST_EVAL.
// An input buffer takes the next item while the current one is at work.
// A restart item starts a clearing pass over all MAX_HEIGHT rows of the visited map,
// during which no buffered item starts. Reset clears control state only.
// A stalled out channel holds the step in its write-back cycle.
`timescale 1ns / 1ps

module maze_backtracker_generator_unit
  import mbg_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RAND_W-1:0]  in_rand_value,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EVENT_W-1:0] out_event_res,
  output logic [COORD_W-1:0] out_wall_x,
  output logic [COORD_W-1:0] out_wall_y,
  output logic [COORD_W-1:0] out_cell_x,
  output logic [COORD_W-1:0] out_cell_y,
  output logic [DEPTH_W-1:0] out_depth,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int SAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int EW    = XW + YW;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [CNTW-1:0]      count_r, count_nxt;
  logic [XW-1:0]        top_x_r, top_x_nxt;
  logic [YW-1:0]        top_y_r, top_y_nxt;
  logic                 buf_v_r;
  logic [RAND_W-1:0]    buf_rand_r;
  logic                 buf_restart_r;
  logic [RAND_W-1:0]    item_rand_r;
  logic                 item_restart_r;
  logic [MAX_WIDTH-1:0] up_row_r;
  logic                 sweep_act_r;
  logic [YW-1:0]        sweep_row_r;
  logic [CFG_W-1:0]     width_cfg_r;
  logic [CFG_W-1:0]     height_cfg_r;
  logic                 out_valid_r;
  event_t               ev_r, ev_nxt;
  logic [COORD_W-1:0]   wall_x_r, wall_x_nxt;
  logic [COORD_W-1:0]   wall_y_r, wall_y_nxt;
  logic [COORD_W-1:0]   cell_x_r, cell_x_nxt;
  logic [COORD_W-1:0]   cell_y_r, cell_y_nxt;
  logic [DEPTH_W-1:0]   depth_r;

  logic                 consume;
  logic                 eval_fire;
  logic                 sweep_start;
  logic [CFG_W-1:0]     w;
  logic [CFG_W-1:0]     h;
  logic [XW-1:0]        lx;
  logic [XW-1:0]        rx;
  logic [XW-1:0]        px;
  logic [YW-1:0]        py;
  logic [NDIR-1:0]      open_mask;
  pick_t                pick;
  logic                 carve_ok;
  logic [MAX_WIDTH-1:0] base_row;

  logic                 vis_rd0_en;
  logic [YW-1:0]        vis_rd0_addr;
  logic [MAX_WIDTH-1:0] vis_rd0_data;
  logic                 vis_rd1_en;
  logic [YW-1:0]        vis_rd1_addr;
  logic [MAX_WIDTH-1:0] vis_rd1_data;
  logic                 vis_wr_en;
  logic [YW-1:0]        vis_wr_addr;
  logic [MAX_WIDTH-1:0] vis_wr_data;
  logic                 eval_vis_wr;

  logic [SAW-1:0]       stk_rd_addr;
  logic [EW-1:0]        stk_rd_data;
  logic                 stk_wr_en;
  logic [SAW-1:0]       stk_wr_addr;
  logic [EW-1:0]        stk_wr_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !buf_v_r;
  assign consume   = (state_r == ST_IDLE) && buf_v_r && !sweep_act_r;
  assign eval_fire = (state_r == ST_EVAL) && (!out_valid_r || out_ready);

  // read addresses: rows y-1 and y+1 at start, row y in the following cycle (ST_RD)
  always_comb begin
    vis_rd0_en = consume || (state_r == ST_RD);
    vis_rd1_en = consume;
    if (state_r == ST_RD) begin
      vis_rd0_addr = top_y_r;
    end else if (top_y_r == '0) begin
      vis_rd0_addr = top_y_r;
    end else begin
      vis_rd0_addr = top_y_r - YW'(1);
    end
    if (int'(top_y_r) + 1 < MAX_HEIGHT) begin
      vis_rd1_addr = top_y_r + YW'(1);
    end else begin
      vis_rd1_addr = top_y_r;
    end
    if (int'(count_r) >= 2) begin
      stk_rd_addr = SAW'(count_r - CNTW'(2));
    end else begin
      stk_rd_addr = '0;
    end
  end

  always_comb begin
    if (width_cfg_r == '0) begin
      w = CFG_W'(1);
    end else if (int'(width_cfg_r) > MAX_WIDTH) begin
      w = CFG_W'(MAX_WIDTH);
    end else begin
      w = width_cfg_r;
    end
    if (height_cfg_r == '0) begin
      h = CFG_W'(1);
    end else if (int'(height_cfg_r) > MAX_HEIGHT) begin
      h = CFG_W'(MAX_HEIGHT);
    end else begin
      h = height_cfg_r;
    end
    lx = (top_x_r == '0) ? top_x_r : top_x_r - XW'(1);
    rx = (int'(top_x_r) + 1 < MAX_WIDTH) ? top_x_r + XW'(1) : top_x_r;
    open_mask[DIR_UP] = (top_y_r != '0) && (int'(top_y_r) - 1 < int'(h))
                        && (int'(top_x_r) < int'(w)) && !up_row_r[top_x_r];
    open_mask[DIR_DOWN] = (int'(top_y_r) + 1 < int'(h))
                          && (int'(top_x_r) < int'(w)) && !vis_rd1_data[top_x_r];
    open_mask[DIR_LEFT] = (top_x_r != '0) && (int'(top_x_r) - 1 < int'(w))
                          && (int'(top_y_r) < int'(h)) && !vis_rd0_data[lx];
    open_mask[DIR_RIGHT] = (int'(top_x_r) + 1 < int'(w))
                           && (int'(top_y_r) < int'(h)) && !vis_rd0_data[rx];
  end

  mbg_pick u_pick (
    .open_mask  (open_mask),
    .rand_value (item_rand_r),
    .pick       (pick)
  );

  always_comb begin
    case (pick.dir)
      DIR_UP: begin
        px = top_x_r;
        py = top_y_r - YW'(1);
        base_row = up_row_r;
      end
      DIR_DOWN: begin
        px = top_x_r;
        py = top_y_r + YW'(1);
        base_row = vis_rd1_data;
      end
      DIR_LEFT: begin
        px = lx;
        py = top_y_r;
        base_row = vis_rd0_data;
      end
      DIR_RIGHT: begin
        px = rx;
        py = top_y_r;
        base_row = vis_rd0_data;
      end
      default: begin
        px = top_x_r;
        py = top_y_r;
        base_row = vis_rd0_data;
      end
    endcase
  end

  assign carve_ok = (phase_r == PH_CARVE) && (count_r != '0) && pick.found
                    && (int'(count_r) < CELLS);

  // step evaluation
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    top_x_nxt   = top_x_r;
    top_y_nxt   = top_y_r;
    ev_nxt      = EV_DONE;
    wall_x_nxt  = '0;
    wall_y_nxt  = '0;
    cell_x_nxt  = '0;
    cell_y_nxt  = '0;
    eval_vis_wr = 1'b0;
    stk_wr_en   = 1'b0;
    stk_wr_addr = '0;
    stk_wr_data = '0;
    sweep_start = 1'b0;
    if (item_restart_r) begin
      ev_nxt      = EV_START;
      cell_x_nxt  = COORD_W'(1);
      cell_y_nxt  = COORD_W'(1);
      count_nxt   = CNTW'(1);
      phase_nxt   = PH_CARVE;
      top_x_nxt   = '0;
      top_y_nxt   = '0;
      stk_wr_en   = 1'b1;
      sweep_start = 1'b1;
    end else if (phase_r == PH_CARVE && count_r != '0) begin
      if (carve_ok) begin
        ev_nxt      = EV_CARVE;
        wall_x_nxt  = COORD_W'(int'(top_x_r) + int'(px) + 1);
        wall_y_nxt  = COORD_W'(int'(top_y_r) + int'(py) + 1);
        cell_x_nxt  = COORD_W'(2 * int'(px) + 1);
        cell_y_nxt  = COORD_W'(2 * int'(py) + 1);
        count_nxt   = count_r + CNTW'(1);
        top_x_nxt   = px;
        top_y_nxt   = py;
        eval_vis_wr = 1'b1;
        stk_wr_en   = 1'b1;
        stk_wr_addr = SAW'(count_r);
        stk_wr_data = {py, px};
      end else begin
        ev_nxt     = EV_BACK;
        cell_x_nxt = COORD_W'(2 * int'(top_x_r) + 1);
        cell_y_nxt = COORD_W'(2 * int'(top_y_r) + 1);
        count_nxt  = count_r - CNTW'(1);
        top_x_nxt  = stk_rd_data[XW-1:0];
        top_y_nxt  = stk_rd_data[EW-1:XW];
        if (count_r == CNTW'(1)) begin
          phase_nxt = PH_ENDS;
        end
      end
    end else if (phase_r == PH_CARVE || phase_r == PH_ENDS) begin
      ev_nxt     = EV_ENDS;
      count_nxt  = '0;
      phase_nxt  = PH_DONE;
      wall_x_nxt = COORD_W'(1);
      cell_x_nxt = COORD_W'(2 * int'(w) - 1);
      cell_y_nxt = COORD_W'(2 * int'(h));
    end
  end

  // write port: clearing pass or carve write-back
  always_comb begin
    if (sweep_act_r) begin
      vis_wr_en   = 1'b1;
      vis_wr_addr = sweep_row_r;
      vis_wr_data = (sweep_row_r == '0) ? MAX_WIDTH'(1) : '0;
    end else begin
      vis_wr_en   = eval_fire && eval_vis_wr;
      vis_wr_addr = py;
      vis_wr_data = base_row | (MAX_WIDTH'(1) << px);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (consume) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  mbg_visit_mem #(
    .ROWS (MAX_HEIGHT),
    .COLS (MAX_WIDTH),
    .AW   (YW)
  ) u_visit_mem (
    .clk      (clk),
    .rd0_en   (vis_rd0_en),
    .rd0_addr (vis_rd0_addr),
    .rd0_data (vis_rd0_data),
    .rd1_en   (vis_rd1_en),
    .rd1_addr (vis_rd1_addr),
    .rd1_data (vis_rd1_data),
    .wr_en    (vis_wr_en),
    .wr_addr  (vis_wr_addr),
    .wr_data  (vis_wr_data)
  );

  mbg_stack_mem #(
    .DEPTH (CELLS),
    .DW    (EW),
    .AW    (SAW)
  ) u_stack_mem (
    .clk     (clk),
    .rd_en   (consume),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data),
    .wr_en   (eval_fire && stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_IDLE;
      count_r      <= '0;
      buf_v_r      <= 1'b0;
      sweep_act_r  <= 1'b0;
      sweep_row_r  <= '0;
      out_valid_r  <= 1'b0;
      width_cfg_r  <= CFG_RESET;
      height_cfg_r <= CFG_RESET;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) begin
        buf_v_r <= 1'b1;
      end else if (consume) begin
        buf_v_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAZE_WIDTH) begin
          width_cfg_r <= cfg_data;
        end else begin
          height_cfg_r <= cfg_data;
        end
      end
      if (sweep_act_r) begin
        sweep_row_r <= sweep_row_r + YW'(1);
        if (sweep_row_r == YW'(MAX_HEIGHT - 1)) begin
          sweep_act_r <= 1'b0;
        end
      end
      if (eval_fire) begin
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        if (sweep_start) begin
          sweep_act_r <= 1'b1;
          sweep_row_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_rand_r    <= in_rand_value;
      buf_restart_r <= in_restart;
    end
    if (consume) begin
      item_rand_r    <= buf_rand_r;
      item_restart_r <= buf_restart_r;
    end
    if (state_r == ST_RD) begin
      up_row_r <= vis_rd0_data;
    end
    if (eval_fire) begin
      top_x_r  <= top_x_nxt;
      top_y_r  <= top_y_nxt;
      ev_r     <= ev_nxt;
      wall_x_r <= wall_x_nxt;
      wall_y_r <= wall_y_nxt;
      cell_x_r <= cell_x_nxt;
      cell_y_r <= cell_y_nxt;
      depth_r  <= DEPTH_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_wall_x    = wall_x_r;
  assign out_wall_y    = wall_y_r;
  assign out_cell_x    = cell_x_r;
  assign out_cell_y    = cell_y_r;
  assign out_depth     = depth_r;

`ifndef SYNTH
  a_sweep_blocks_start: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_act_r |-> !consume)
    else $error("item started during visited-map clear");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CELLS)
    else $error("stack depth above cell count");

  a_carve_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (eval_fire && ev_nxt == EV_CARVE) |=> (count_r == $past(count_r) + CNTW'(1)))
    else $error("carve did not push exactly one cell");

  a_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ENDS || phase_r == PH_DONE) |-> (count_r == '0))
    else $error("stack not empty after carving finished");
`endif

endmodule

>>> sim/maze_carve_checker.sv
// Checker: mirrors the maze carver state, predicts each result item and compares it.
`timescale 1ns / 1ps

module maze_carve_checker
  import mbg_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [RAND_W-1:0]  in_rand_value,
  input  logic               in_restart,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [EVENT_W-1:0] out_event_res,
  input  logic [COORD_W-1:0] out_wall_x,
  input  logic [COORD_W-1:0] out_wall_y,
  input  logic [COORD_W-1:0] out_cell_x,
  input  logic [COORD_W-1:0] out_cell_y,
  input  logic [DEPTH_W-1:0] out_depth,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int unsigned        awaiting,
  output int unsigned        failures
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    event_t               code;
    logic [COORD_W-1:0]   wall_x;
    logic [COORD_W-1:0]   wall_y;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [DEPTH_W-1:0]   depth;
  } move_t;

  logic             visited [CELLS];
  int unsigned      trail [CELLS];
  int unsigned      trail_len;
  phase_t           phase;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  move_t            pending_moves [$];
  int unsigned      fail_count = 0;

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic move_t make_move(input event_t code, input int wx, input int wy,
                                      input int cx, input int cy, input int unsigned depth);
    move_t m;
    m.code   = code;
    m.wall_x = COORD_W'(wx);
    m.wall_y = COORD_W'(wy);
    m.cell_x = COORD_W'(cx);
    m.cell_y = COORD_W'(cy);
    m.depth  = DEPTH_W'(depth);
    return m;
  endfunction

  // one step on the mirrored maze: restart, carve, backtrack, ends or done
  task automatic predict_move(input logic [RAND_W-1:0] rnd, input logic restart,
                              output move_t m);
    int          w, h, cx, cy, nx, ny, px, py;
    int unsigned top, n, sel, pick;
    int unsigned cand [NDIR];
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    if (restart) begin
      foreach (visited[i]) visited[i] = 1'b0;
      visited[0] = 1'b1;
      trail[0]   = 0;
      trail_len  = 1;
      phase      = PH_CARVE;
      m = make_move(EV_START, 0, 0, 1, 1, trail_len);
    end else if (phase == PH_CARVE && trail_len > 0) begin
      top = trail[trail_len-1];
      cx  = top % MAX_WIDTH;
      cy  = top / MAX_WIDTH;
      n   = 0;
      for (int d = 0; d < NDIR; d++) begin
        nx = cx;
        ny = cy;
        case (dir_t'(d))
          DIR_UP:    ny = cy - 1;
          DIR_DOWN:  ny = cy + 1;
          DIR_LEFT:  nx = cx - 1;
          DIR_RIGHT: nx = cx + 1;
          default:   ;
        endcase
        if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
          if (!visited[ny*MAX_WIDTH + nx]) begin
            cand[n] = ny*MAX_WIDTH + nx;
            n++;
          end
        end
      end
      if (n > 0 && trail_len < CELLS) begin
        sel  = (32'(rnd) * n) >> 16;
        pick = cand[sel];
        px   = pick % MAX_WIDTH;
        py   = pick / MAX_WIDTH;
        visited[pick]    = 1'b1;
        trail[trail_len] = pick;
        trail_len++;
        m = make_move(EV_CARVE, cx + px + 1, cy + py + 1, 2*px + 1, 2*py + 1, trail_len);
      end else begin
        trail_len--;
        if (trail_len == 0) phase = PH_ENDS;
        m = make_move(EV_BACK, 0, 0, 2*cx + 1, 2*cy + 1, trail_len);
      end
    end else begin
      if (phase == PH_CARVE) begin
        trail_len = 0;
        phase     = PH_ENDS;
      end
      if (phase == PH_ENDS) begin
        phase = PH_DONE;
        m = make_move(EV_ENDS, 1, 0, 2*w - 1, 2*h, trail_len);
      end else begin
        m = make_move(EV_DONE, 0, 0, 0, 0, trail_len);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    move_t m;
    if (!rst_n) begin
      foreach (visited[i]) visited[i] = 1'b0;
      trail_len  = 0;
      phase      = PH_IDLE;
      width_reg  = CFG_RESET;
      height_reg = CFG_RESET;
      pending_moves.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAZE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict_move(in_rand_value, in_restart, m);
        pending_moves.push_back(m);
      end
      if (out_valid && out_ready) begin
        if (pending_moves.size() == 0) begin
          $display("%0t: result item with none expected, expected nothing, actual event %0d",
                   $time, out_event_res);
          fail_count++;
        end else begin
          m = pending_moves.pop_front();
          check_field("event", m.code, out_event_res);
          check_field("wall_x", m.wall_x, out_wall_x);
          check_field("wall_y", m.wall_y, out_wall_y);
          check_field("cell_x", m.cell_x, out_cell_x);
          check_field("cell_y", m.cell_y, out_cell_y);
          check_field("depth", m.depth, out_depth);
        end
      end
    end
    awaiting <= pending_moves.size();
    failures <= fail_count;
  end

endmodule

>>> sim/testbench.sv
// Top: clock, reset, stimulus and verdict for the maze carver.
`timescale 1ns / 1ps

module testbench;
  import mbg_pkg::*;

  localparam int MAX_WIDTH    = 32;
  localparam int MAX_HEIGHT   = 32;
  localparam int SETTLE       = 2*MAX_HEIGHT + 8;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [RAND_W-1:0]  in_rand_value;
  logic               in_restart;
  logic               out_valid;
  logic               out_ready;
  logic [EVENT_W-1:0] out_event_res;
  logic [COORD_W-1:0] out_wall_x;
  logic [COORD_W-1:0] out_wall_y;
  logic [COORD_W-1:0] out_cell_x;
  logic [COORD_W-1:0] out_cell_y;
  logic [DEPTH_W-1:0] out_depth;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  int unsigned        awaiting;
  int unsigned        failures;

  int unsigned sent = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  always #5 clk = ~clk;

  maze_backtracker_generator_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) uut (.*);

  maze_carve_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) carve_check (.*);

  task automatic send_step(input logic [RAND_W-1:0] rnd, input logic restart);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rand_value <= rnd;
    in_restart    <= restart;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // stop sending and let every outstanding item and the clear pass finish
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                          input logic [1:0] which);
    if (which[0]) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_MAZE_WIDTH;
      cfg_data  <= w;
      do @(posedge clk); while (!cfg_ready);
    end
    if (which[1]) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_MAZE_HEIGHT;
      cfg_data  <= h;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RAND_W-1:0] any_rand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return RAND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int cells_of(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // stimulus
  initial begin
    logic [CFG_W-1:0] w, h;
    int               steps;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_rand_value <= '0;
    in_restart    <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_MAZE_WIDTH;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // idle before any restart, then a short start at the reset size
    send_step(16'h0000, 1'b0);
    send_step(16'hFFFF, 1'b0);
    send_step(16'hFFFF, 1'b1);
    send_step(16'h0000, 1'b0);
    send_step(16'h8000, 1'b0);
    drain_and_settle();

    // zero size clamps to one cell: start, backtrack, ends, done, restart from done
    set_size('0, '0, 2'b11);
    send_step(16'hFFFF, 1'b1);
    send_step(16'h0000, 1'b0);
    send_step(16'h0001, 1'b0);
    send_step(16'hFFFF, 1'b0);
    send_step(16'h5555, 1'b1);
    drain_and_settle();

    // oversize clamps to the maximum; restart in the middle of carving
    set_size('1, '1, 2'b11);
    send_step(16'h0000, 1'b1);
    send_step(16'h0000, 1'b0);
    send_step(16'hFFFF, 1'b0);
    send_step(16'h8000, 1'b0);
    send_step(16'h5555, 1'b0);
    send_step(16'hAAAA, 1'b0);
    send_step(16'h7FFF, 1'b1);
    send_step(16'hFFFF, 1'b0);
    send_step(16'h0000, 1'b0);
    drain_and_settle();

    // single column at full height
    set_size(6'd1, 6'd32, 2'b11);
    send_step(16'h1234, 1'b1);
    send_step(16'hFFFF, 1'b0);
    send_step(16'hFFFF, 1'b0);
    send_step(16'h0000, 1'b0);
    send_step(16'h0000, 1'b0);

    while (sent < 25 + RANDOM_ITEMS) begin
      drain_and_settle();
      if ($urandom_range(0, 9) < 8) begin
        w = CFG_W'($urandom_range(1, 6));
        h = CFG_W'($urandom_range(1, 6));
      end else begin
        w = CFG_W'($urandom_range(0, 63));
        h = CFG_W'($urandom_range(0, 63));
      end
      // one register only now and then, so the other keeps its old value
      set_size(w, h, 2'($urandom_range(1, 3)));
      send_burst = ($urandom_range(0, 3) == 0);
      steps = 2 * cells_of(w, MAX_WIDTH) * cells_of(h, MAX_HEIGHT) + 2 + $urandom_range(0, 2);
      if (steps > 90) steps = $urandom_range(30, 90);
      // most phases start a fresh maze; others carry on with the resized one
      if ($urandom_range(0, 3) != 0) send_step(any_rand(), 1'b1);
      repeat (steps) send_step(any_rand(), $urandom_range(0, 39) == 0);
    end

    drain_and_settle();
    if (failures == 0 && awaiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
      hold = recv_burst ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
